// ===== hw/rtl/stdq_pkg.sv =====
// Shared types and constants for the sorted table and deque block.
// Used by stdq_ctrl, stdq_dp and sorted_table_and_deque; no dependencies.
`default_nettype none

package stdq_pkg;

  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int CAP_W    = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_SIGNED = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_END   = 3'd0,
    CMD_POP_END    = 3'd1,
    CMD_PEEK_END   = 3'd2,
    CMD_PUSH_FRONT = 3'd3,
    CMD_POP_FRONT  = 3'd4,
    CMD_INSERT     = 3'd5,
    CMD_DELETE     = 3'd6,
    CMD_FIND       = 3'd7
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_DUP     = 3'd3,
    ST_MISSING = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SRCH,
    S_SRCH_CMP,
    S_END_CAP,
    S_POPF_CAP,
    S_OPEN_RD,
    S_OPEN_WR,
    S_CLOSE_RD,
    S_CLOSE_WR,
    S_DONE
  } state_e;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_LOAD,
    DP_SET_FULL,
    DP_SET_EMPTY,
    DP_PUSH_END,
    DP_READ_END,
    DP_POP_END,
    DP_CAPTURE,
    DP_OPEN_INIT,
    DP_POPF_RD,
    DP_POPF_CAP,
    DP_SRCH_RD,
    DP_SRCH_STEP,
    DP_MISS_OPEN,
    DP_MISS,
    DP_HIT_DUP,
    DP_HIT,
    DP_OPEN_RD,
    DP_OPEN_WR,
    DP_OPEN_FILL,
    DP_CLOSE_RD,
    DP_CLOSE_WR,
    DP_CLOSE_END
  } dp_op_e;

  typedef struct packed {
    cmd_e opcode;
    logic full;
    logic empty;
    logic srch_open;
    logic cmp_gt;
    logic cmp_lt;
    logic open_more;
    logic close_more;
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stdq_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module stdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stdq_ctrl.sv =====
// Command sequencer for the sorted table and deque.
// Depends on stdq_pkg; drives stdq_dp through dp_op_e and reads stat_t.
`default_nettype none

module stdq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire stdq_pkg::stat_t  stat,
  output stdq_pkg::dp_op_e      op,
  output logic                  busy,
  output logic                  done
);

  import stdq_pkg::*;

  state_e state, state_next;
  logic   cmp_eq;

  assign cmp_eq = !stat.cmp_gt && !stat.cmp_lt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_CHECK;
      end
      S_CHECK: begin
        case (stat.opcode)
          CMD_PUSH_END:   state_next = S_DONE;
          CMD_POP_END,
          CMD_PEEK_END:   state_next = stat.empty ? S_DONE : S_END_CAP;
          CMD_PUSH_FRONT: state_next = stat.full ? S_DONE : S_OPEN_RD;
          CMD_POP_FRONT:  state_next = stat.empty ? S_DONE : S_POPF_CAP;
          CMD_INSERT:     state_next = stat.full ? S_DONE : S_SRCH;
          CMD_DELETE:     state_next = stat.empty ? S_DONE : S_SRCH;
          CMD_FIND:       state_next = S_SRCH;
          default:        state_next = S_DONE;
        endcase
      end
      S_SRCH: begin
        if (stat.srch_open) begin
          state_next = S_SRCH_CMP;
        end else if (stat.opcode == CMD_INSERT) begin
          state_next = S_OPEN_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SRCH_CMP: begin
        if (!cmp_eq) begin
          state_next = S_SRCH;
        end else if (stat.opcode == CMD_DELETE) begin
          state_next = S_CLOSE_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_END_CAP:  state_next = S_DONE;
      S_POPF_CAP: state_next = S_CLOSE_RD;
      S_OPEN_RD:  state_next = stat.open_more ? S_OPEN_WR : S_DONE;
      S_OPEN_WR:  state_next = S_OPEN_RD;
      S_CLOSE_RD: state_next = stat.close_more ? S_CLOSE_WR : S_DONE;
      S_CLOSE_WR: state_next = S_CLOSE_RD;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    op = DP_NONE;
    case (state)
      S_IDLE: begin
        if (start) op = DP_LOAD;
      end
      S_CHECK: begin
        case (stat.opcode)
          CMD_PUSH_END:   op = stat.full ? DP_SET_FULL : DP_PUSH_END;
          CMD_POP_END:    op = stat.empty ? DP_SET_EMPTY : DP_POP_END;
          CMD_PEEK_END:   op = stat.empty ? DP_SET_EMPTY : DP_READ_END;
          CMD_PUSH_FRONT: op = stat.full ? DP_SET_FULL : DP_OPEN_INIT;
          CMD_POP_FRONT:  op = stat.empty ? DP_SET_EMPTY : DP_POPF_RD;
          CMD_INSERT:     op = stat.full ? DP_SET_FULL : DP_NONE;
          CMD_DELETE:     op = stat.empty ? DP_SET_EMPTY : DP_NONE;
          default:        op = DP_NONE;
        endcase
      end
      S_SRCH: begin
        if (stat.srch_open) begin
          op = DP_SRCH_RD;
        end else if (stat.opcode == CMD_INSERT) begin
          op = DP_MISS_OPEN;
        end else begin
          op = DP_MISS;
        end
      end
      S_SRCH_CMP: begin
        if (!cmp_eq) begin
          op = DP_SRCH_STEP;
        end else if (stat.opcode == CMD_INSERT) begin
          op = DP_HIT_DUP;
        end else begin
          op = DP_HIT;
        end
      end
      S_END_CAP:  op = DP_CAPTURE;
      S_POPF_CAP: op = DP_POPF_CAP;
      S_OPEN_RD:  op = stat.open_more ? DP_OPEN_RD : DP_OPEN_FILL;
      S_OPEN_WR:  op = DP_OPEN_WR;
      S_CLOSE_RD: op = stat.close_more ? DP_CLOSE_RD : DP_CLOSE_END;
      S_CLOSE_WR: op = DP_CLOSE_WR;
      default:    op = DP_NONE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

`default_nettype wire

// ===== hw/rtl/stdq_dp.sv =====
// Datapath: table RAM, fill count, bisection bounds, shift pointer, result regs.
// Depends on stdq_pkg and stdq_ram; sequenced by stdq_ctrl.
`default_nettype none

module stdq_dp #(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire stdq_pkg::dp_op_e                   op,
  input  wire logic [stdq_pkg::CMD_W-1:0]         command,
  input  wire logic [stdq_pkg::VALUE_W-1:0]       item_value,
  input  wire logic                               cfg_wr_en,
  input  wire logic [stdq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [stdq_pkg::CAP_W-1:0]         cfg_wr_data,
  output stdq_pkg::stat_t                         stat,
  output logic      [stdq_pkg::STATUS_W-1:0]      status,
  output logic      [stdq_pkg::VALUE_W-1:0]       out_value,
  output logic      [stdq_pkg::POS_W-1:0]         position,
  output logic      [stdq_pkg::POS_W-1:0]         count_now
);

  import stdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  cmd_e                  opcode;
  status_e               status_q;
  logic [ITEM_WIDTH-1:0] item_q;
  logic [ITEM_WIDTH-1:0] value_q;
  logic [CW-1:0]         count;
  logic [CW-1:0]         lo;
  logic [CW-1:0]         hi;
  logic [CW-1:0]         pos;
  logic [CW-1:0]         idx;
  logic [CAP_W-1:0]      capacity;
  logic                  csigned;

  logic [CW:0]           mid_sum;
  logic [CW-1:0]         mid;
  logic [CW-1:0]         count_dec;
  logic [CW-1:0]         idx_dec;
  logic [CW:0]           idx_inc;
  logic [LW-1:0]         lim;
  logic [ITEM_WIDTH-1:0] sgn;
  logic [ITEM_WIDTH-1:0] key_a;
  logic [ITEM_WIDTH-1:0] key_b;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ITEM_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [ITEM_WIDTH-1:0] ram_rdata;

  stdq_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[CW:1];
  assign count_dec = count - CW'(1);
  assign idx_dec   = idx - CW'(1);
  assign idx_inc   = {1'b0, idx} + (CW+1)'(1);
  assign lim       = (LW'(capacity) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(capacity);

  // two's complement order: flip the sign bit and compare unsigned
  assign sgn   = ITEM_WIDTH'(csigned) << (ITEM_WIDTH - 1);
  assign key_a = item_q ^ sgn;
  assign key_b = ram_rdata ^ sgn;

  always_comb begin
    stat.opcode     = opcode;
    stat.full       = (LW'(count) >= lim);
    stat.empty      = (count == '0);
    stat.srch_open  = (lo < hi);
    stat.cmp_gt     = (key_a > key_b);
    stat.cmp_lt     = (key_a < key_b);
    stat.open_more  = (idx > pos);
    stat.close_more = (idx_inc < {1'b0, count});
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[AW-1:0];
    ram_wdata = item_q;
    ram_raddr = '0;
    case (op)
      DP_PUSH_END: begin
        ram_we    = 1'b1;
        ram_waddr = count[AW-1:0];
      end
      DP_READ_END,
      DP_POP_END:   ram_raddr = count_dec[AW-1:0];
      DP_SRCH_RD:   ram_raddr = mid[AW-1:0];
      DP_OPEN_RD:   ram_raddr = idx_dec[AW-1:0];
      DP_CLOSE_RD:  ram_raddr = idx_inc[AW-1:0];
      DP_OPEN_WR,
      DP_CLOSE_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      DP_OPEN_FILL: ram_we = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      capacity <= CAP_RESET;
      csigned  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_CAPACITY:       capacity <= cfg_wr_data;
          CFG_COMPARE_SIGNED: csigned  <= cfg_wr_data[0];
          default: begin
          end
        endcase
      end
      case (op)
        DP_PUSH_END,
        DP_OPEN_FILL: count <= count + CW'(1);
        DP_POP_END,
        DP_CLOSE_END: count <= count_dec;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      DP_LOAD: begin
        opcode   <= cmd_e'(command);
        item_q   <= ITEM_WIDTH'(item_value);
        status_q <= ST_OK;
        value_q  <= '0;
        pos      <= '0;
        lo       <= '0;
        hi       <= count;
      end
      DP_SET_FULL:  status_q <= ST_FULL;
      DP_SET_EMPTY: status_q <= ST_EMPTY;
      DP_PUSH_END:  pos <= count;
      DP_READ_END,
      DP_POP_END:   pos <= count_dec;
      DP_CAPTURE:   value_q <= ram_rdata;
      DP_OPEN_INIT: idx <= count;
      DP_POPF_CAP: begin
        value_q <= ram_rdata;
        idx     <= '0;
      end
      DP_SRCH_STEP: begin
        if (stat.cmp_gt) begin
          lo <= mid + CW'(1);
        end else begin
          hi <= mid;
        end
      end
      DP_MISS_OPEN: begin
        pos <= lo;
        idx <= count;
      end
      DP_MISS: begin
        pos      <= lo;
        status_q <= ST_MISSING;
      end
      DP_HIT_DUP: begin
        pos      <= mid;
        status_q <= ST_DUP;
      end
      DP_HIT: begin
        pos <= mid;
        idx <= mid;
      end
      DP_OPEN_WR:  idx <= idx_dec;
      DP_CLOSE_WR: idx <= idx_inc[CW-1:0];
      default: begin
      end
    endcase
  end

  assign status    = status_q;
  assign out_value = VALUE_W'(value_q);
  assign position  = POS_W'(pos);
  assign count_now = POS_W'(count);

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_table_and_deque.sv =====
// Sorted table and deque: one command per start, one result per command, marked
// by a single-cycle done strobe that the receiver must take. start is taken when
// busy is low; push_end and any full or empty outcome go from the check state
// straight to done, while pop_end and peek_end first capture the read data. Each
// search bisection step (about log2 of the count) is a read then a compare, and a
// search with no matching entry ends with one more bound check. Every entry that
// an insert, delete, push_front or pop_front moves is a read then a write, through
// the table RAM's single read port, and each shift ends with its closing write or
// count update. busy stays high until the cycle after done. Configuration writes
// are taken at any edge with cfg_wr_en high and must be issued while busy is low.
`default_nettype none

module sorted_table_and_deque #(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [stdq_pkg::CMD_W-1:0]     command,
  input  wire logic [stdq_pkg::VALUE_W-1:0]   item_value,
  input  wire logic                           cfg_wr_en,
  input  wire logic [stdq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [stdq_pkg::CAP_W-1:0]     cfg_wr_data,
  output logic                                busy,
  output logic                                done,
  output logic      [stdq_pkg::STATUS_W-1:0]  status,
  output logic      [stdq_pkg::VALUE_W-1:0]   out_value,
  output logic      [stdq_pkg::POS_W-1:0]     position,
  output logic      [stdq_pkg::POS_W-1:0]     count_now
);

  import stdq_pkg::*;

  stat_t   stat;
  dp_op_e  op;

  stdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .op    (op),
    .busy  (busy),
    .done  (done)
  );

  stdq_dp #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .command     (command),
    .item_value  (item_value),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .stat        (stat),
    .status      (status),
    .out_value   (out_value),
    .position    (position),
    .count_now   (count_now)
  );

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted command did not start a sequence");

  a_err_no_value: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> (out_value == '0))
    else $error("error result carries a value");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (busy && $past(busy)))
    else $error("done without a running command");

endmodule

`default_nettype wire
